// ----- rtl/bcg_pkg.sv -----
package bcg_pkg;

    // Command codes carried in the command field of an input item.
    localparam logic CMD_SAMPLE     = 1'b0;
    localparam logic CMD_DISCONNECT = 1'b1;

    // Charger modes; codes above MODE_OTHER behave like MODE_OTHER.
    localparam logic [2:0] MODE_CHARGE      = 3'd0;
    localparam logic [2:0] MODE_CHARGE_FULL = 3'd1;
    localparam logic [2:0] MODE_IDLE        = 3'd2;
    localparam logic [2:0] MODE_IDLE0       = 3'd3;
    localparam logic [2:0] MODE_OTHER       = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_TEMP_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_TEMP_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TEMP_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TEMP_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_VOLTAGE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_VOLTAGE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_V_TIMEOUT   = 3'd6;
    localparam int unsigned CFG_DATA_W = 48;

    // Configuration reset values.
    localparam logic [7:0]  RST_CHARGE_TEMP_MIN = 8'd0;
    localparam logic [7:0]  RST_CHARGE_TEMP_MAX = 8'd60;
    localparam logic [7:0]  RST_START_TEMP_MIN  = 8'd0;
    localparam logic [7:0]  RST_START_TEMP_MAX  = 8'd45;
    localparam logic [15:0] RST_OVER_VOLTAGE    = 16'd9000;
    localparam logic [15:0] RST_UNDER_VOLTAGE   = 16'd5888;
    localparam logic [47:0] RST_LOW_V_TIMEOUT   = 48'd7200000000;

    // Temperature conversion: Celsius = (dK - 2731) / 10, toward zero.
    localparam logic [16:0] KELVIN_OFFSET_DK = 17'd2731;
    // x / 10 == (x * 0xCCCD) >> 19 for every x below 2^18.
    localparam logic [31:0] DIV10_MUL   = 32'h0000_CCCD;
    localparam int unsigned DIV10_SHIFT = 19;
    // x / 5 == (x * 0xCCCD) >> 18 for every x below 2^18.
    localparam logic [33:0] DIV5_MUL    = 34'h0_0000_CCCD;
    localparam int unsigned DIV5_SHIFT  = 18;

    typedef struct packed {
        logic        command;
        logic [15:0] temperature_dk;
        logic [15:0] voltage_mv;
        logic [2:0]  charger_mode;
        logic [15:0] capacity_mah;
        logic [15:0] request_voltage_mv;
        logic [15:0] request_current_ma;
        logic [47:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic [15:0] desired_voltage_mv;
        logic [15:0] desired_current_ma;
        logic        force_bad_voltage;
        logic        clear_want_charge;
        logic        error_latched;
        logic        charge_stopped;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  charge_temp_min_c;
        logic [7:0]  charge_temp_max_c;
        logic [7:0]  start_temp_min_c;
        logic [7:0]  start_temp_max_c;
        logic [15:0] over_voltage_mv;
        logic [15:0] under_voltage_mv;
        logic [47:0] low_voltage_timeout_us;
    } t_cfg;

    // An item after temperature and current conversion.
    typedef struct packed {
        logic               command;
        logic signed [15:0] temp_c;
        logic [15:0]        voltage_mv;
        logic [2:0]         charger_mode;
        logic [15:0]        request_voltage_mv;
        logic [15:0]        request_current_ma;
        logic [15:0]        scaled_current_ma;
        logic [47:0]        now_us;
    } t_conv_item;

endpackage

// ----- rtl/battery_charge_guard_top.sv -----
// Battery charge guard. Each transfer on the input channel carries one battery
// sample (or a disconnect event), and each sample yields one transfer on the
// output channel with the charge voltage and current after the temperature and
// voltage guards have had their say; a disconnect event clears the error and
// stop flags and yields no output transfer. The block takes one input transfer
// in every clock cycle when the output side keeps up. An item passes three
// registers: the input register, the conversion register (temperature in
// Celsius and the scaled charge current, each from one constant multiplier)
// and the output register, from which the result is offered. The guard flags
// and the low-voltage start time live beside the last stage and are updated
// as each item leaves the conversion register, so consecutive items see each
// other's effect without any bubble. The user must write configuration
// registers through the plain write port only while the block holds no item,
// which the block does not enforce; writes beyond the last index are ignored.
module battery_charge_guard_top
    import bcg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_cv_valid;
    t_conv_item r_cv_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    t_conv_item conv_item;
    t_out_item  guard_result;

    logic out_free;
    logic cv_fire;
    logic cv_free;
    logic in_fire;
    logic in_free;
    logic cv_has_result;

    // Handshake chain, from the output backwards. A disconnect event leaves
    // the conversion register without waiting for room at the output.
    always_comb begin
        out_free      = !r_out_valid || i_out_ready;
        cv_has_result = r_cv_item.command == CMD_SAMPLE;
        cv_fire       = r_cv_valid && (!cv_has_result || out_free);
        cv_free       = !r_cv_valid || cv_fire;
        in_fire       = r_in_valid && cv_free;
        in_free       = !r_in_valid || cv_free;
    end

    assign o_in_ready  = in_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    bcg_convert u_convert (
        .i_item (r_in_item),
        .o_item (conv_item)
    );

    bcg_guard u_guard (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (cv_fire),
        .i_item   (r_cv_item),
        .i_cfg    (r_cfg),
        .o_result (guard_result)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.charge_temp_min_c      <= RST_CHARGE_TEMP_MIN;
            r_cfg.charge_temp_max_c      <= RST_CHARGE_TEMP_MAX;
            r_cfg.start_temp_min_c       <= RST_START_TEMP_MIN;
            r_cfg.start_temp_max_c       <= RST_START_TEMP_MAX;
            r_cfg.over_voltage_mv        <= RST_OVER_VOLTAGE;
            r_cfg.under_voltage_mv       <= RST_UNDER_VOLTAGE;
            r_cfg.low_voltage_timeout_us <= RST_LOW_V_TIMEOUT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CHARGE_TEMP_MIN: r_cfg.charge_temp_min_c      <= i_cfg_wdata[7:0];
                CFG_CHARGE_TEMP_MAX: r_cfg.charge_temp_max_c      <= i_cfg_wdata[7:0];
                CFG_START_TEMP_MIN:  r_cfg.start_temp_min_c       <= i_cfg_wdata[7:0];
                CFG_START_TEMP_MAX:  r_cfg.start_temp_max_c       <= i_cfg_wdata[7:0];
                CFG_OVER_VOLTAGE:    r_cfg.over_voltage_mv        <= i_cfg_wdata[15:0];
                CFG_UNDER_VOLTAGE:   r_cfg.under_voltage_mv       <= i_cfg_wdata[15:0];
                CFG_LOW_V_TIMEOUT:   r_cfg.low_voltage_timeout_us <= i_cfg_wdata[47:0];
                default: begin
                end
            endcase
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_cv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_in_valid;
            end
            if (cv_free) begin
                r_cv_valid <= in_fire;
            end
            if (out_free) begin
                r_out_valid <= cv_fire && cv_has_result;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (in_fire) begin
            r_cv_item <= conv_item;
        end
        if (cv_fire && cv_has_result) begin
            r_out_item <= guard_result;
        end
    end

endmodule

// ----- rtl/bcg_convert.sv -----
module bcg_convert
    import bcg_pkg::*;
(
    input  t_in_item   i_item,
    output t_conv_item o_item
);

    logic [16:0]        diff_dk;
    logic [16:0]        neg_diff_dk;
    logic               below_zero;
    logic [15:0]        mag_dk;
    logic [31:0]        prod_temp;
    logic signed [15:0] quot_c;
    logic [17:0]        cap_x3;
    logic [33:0]        prod_cur;

    always_comb begin
        // Work on the magnitude so that the quotient truncates toward zero.
        diff_dk     = {1'b0, i_item.temperature_dk} - KELVIN_OFFSET_DK;
        neg_diff_dk = ~diff_dk + 17'd1;
        below_zero  = diff_dk[16];
        mag_dk      = below_zero ? neg_diff_dk[15:0] : diff_dk[15:0];
        prod_temp   = {16'd0, mag_dk} * DIV10_MUL;
        quot_c      = $signed({3'd0, prod_temp[DIV10_SHIFT+12:DIV10_SHIFT]});

        // Capacity * 6 / 10 is worked out as (capacity * 3) / 5.
        cap_x3   = {1'b0, i_item.capacity_mah, 1'b0} + {2'd0, i_item.capacity_mah};
        prod_cur = {16'd0, cap_x3} * DIV5_MUL;

        o_item.command            = i_item.command;
        o_item.temp_c             = below_zero ? -quot_c : quot_c;
        o_item.voltage_mv         = i_item.voltage_mv;
        o_item.charger_mode       = i_item.charger_mode;
        o_item.request_voltage_mv = i_item.request_voltage_mv;
        o_item.request_current_ma = i_item.request_current_ma;
        o_item.scaled_current_ma  = prod_cur[DIV5_SHIFT+15:DIV5_SHIFT];
        o_item.now_us             = i_item.now_us;
    end

endmodule

// ----- rtl/bcg_guard.sv -----
module bcg_guard
    import bcg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_conv_item i_item,
    input  t_cfg       i_cfg,
    output t_out_item  o_result
);

    logic        r_error;
    logic        n_error;
    logic        r_stop;
    logic        n_stop;
    logic [47:0] r_lv_start;
    logic [47:0] n_lv_start;

    logic               charging;
    logic               idle;
    logic signed [15:0] chg_min;
    logic signed [15:0] chg_max;
    logic signed [15:0] st_min;
    logic signed [15:0] st_max;
    logic               chg_out_of_window;
    logic               st_out_of_window;
    logic [47:0]        elapsed_us;

    always_comb begin
        charging = (i_item.charger_mode == MODE_CHARGE)
                || (i_item.charger_mode == MODE_CHARGE_FULL);
        idle     = (i_item.charger_mode == MODE_IDLE)
                || (i_item.charger_mode == MODE_IDLE0);

        chg_min = $signed({{8{i_cfg.charge_temp_min_c[7]}}, i_cfg.charge_temp_min_c});
        chg_max = $signed({{8{i_cfg.charge_temp_max_c[7]}}, i_cfg.charge_temp_max_c});
        st_min  = $signed({{8{i_cfg.start_temp_min_c[7]}}, i_cfg.start_temp_min_c});
        st_max  = $signed({{8{i_cfg.start_temp_max_c[7]}}, i_cfg.start_temp_max_c});

        chg_out_of_window = (i_item.temp_c < chg_min) || (i_item.temp_c >= chg_max);
        st_out_of_window  = (i_item.temp_c < st_min) || (i_item.temp_c >= st_max);

        // The timer difference wraps with the 48-bit timestamp.
        elapsed_us = i_item.now_us - r_lv_start;

        n_error    = r_error;
        n_stop     = r_stop;
        n_lv_start = r_lv_start;

        if (i_item.command == CMD_DISCONNECT) begin
            n_error = 1'b0;
            n_stop  = 1'b0;
        end else begin
            if (charging) begin
                n_stop = r_stop | chg_out_of_window;
            end else begin
                n_stop = st_out_of_window;
            end

            if (!r_error) begin
                if (charging) begin
                    priority if (i_item.voltage_mv > i_cfg.over_voltage_mv) begin
                        n_error = 1'b1;
                    end else if (i_item.voltage_mv < i_cfg.under_voltage_mv) begin
                        n_error = elapsed_us > i_cfg.low_voltage_timeout_us;
                    end else begin
                        n_lv_start = i_item.now_us;
                    end
                end else if (idle) begin
                    n_lv_start = i_item.now_us;
                end
            end
        end

        o_result.error_latched  = n_error;
        o_result.charge_stopped = n_stop;
        priority if (n_error) begin
            o_result.desired_voltage_mv = 16'd0;
            o_result.desired_current_ma = 16'd0;
            o_result.force_bad_voltage  = 1'b1;
            o_result.clear_want_charge  = 1'b0;
        end else if (n_stop) begin
            o_result.desired_voltage_mv = 16'd0;
            o_result.desired_current_ma = 16'd0;
            o_result.force_bad_voltage  = 1'b0;
            o_result.clear_want_charge  = 1'b1;
        end else begin
            o_result.desired_voltage_mv = i_item.request_voltage_mv;
            o_result.desired_current_ma = (i_item.charger_mode == MODE_CHARGE)
                                        ? i_item.scaled_current_ma
                                        : i_item.request_current_ma;
            o_result.force_bad_voltage  = 1'b0;
            o_result.clear_want_charge  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error    <= 1'b0;
            r_stop     <= 1'b0;
            r_lv_start <= 48'd0;
        end else if (i_fire) begin
            r_error    <= n_error;
            r_stop     <= n_stop;
            r_lv_start <= n_lv_start;
        end
    end

endmodule

// ----- rtl/bcg_checker.sv -----
module bcg_props
    import bcg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             o_out_item,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // After reset the pipeline is empty: nothing offered and room to take.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or withdrawn");

    // The error override blanks the requests and tracks the error flag.
    a_error_override: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.force_bad_voltage == o_out_item.error_latched)
            && (!o_out_item.force_bad_voltage
                || (o_out_item.desired_voltage_mv == 16'd0
                    && o_out_item.desired_current_ma == 16'd0
                    && !o_out_item.clear_want_charge)))
        else $error("error override inconsistent");

    // The stop override only appears with the stop flag and without error.
    a_stop_override: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.clear_want_charge
            |-> o_out_item.charge_stopped && !o_out_item.error_latched
                && o_out_item.desired_voltage_mv == 16'd0
                && o_out_item.desired_current_ma == 16'd0)
        else $error("stop override inconsistent");

endmodule

bind battery_charge_guard_top bcg_props u_bcg_props (.*);
